[src/assert_macros.svh]
// assertion macros shared by the health edge rule engine rtl
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define HER_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define HER_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/her_pkg.sv]
// shared types, codes and helper functions for the health edge rule engine
// no dependencies
package her_pkg;

    // candidate pair slots, in emission order
    localparam int NUM_SLOTS  = 7;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int ACTION_CAP = 7;

    localparam logic [SLOT_IDX_W-1:0] SLOT_RECLAIM   = SLOT_IDX_W'(0);
    localparam logic [SLOT_IDX_W-1:0] SLOT_TRIM      = SLOT_IDX_W'(1);
    localparam logic [SLOT_IDX_W-1:0] SLOT_THERM_SCN = SLOT_IDX_W'(2);
    localparam logic [SLOT_IDX_W-1:0] SLOT_ESCALATE  = SLOT_IDX_W'(3);
    localparam logic [SLOT_IDX_W-1:0] SLOT_SAT_SCN   = SLOT_IDX_W'(4);
    localparam logic [SLOT_IDX_W-1:0] SLOT_REBALANCE = SLOT_IDX_W'(5);
    localparam logic [SLOT_IDX_W-1:0] SLOT_BIAS      = SLOT_IDX_W'(6);

    // rule codes
    localparam logic [2:0] RULE_MEM     = 3'd0;
    localparam logic [2:0] RULE_THERMAL = 3'd1;
    localparam logic [2:0] RULE_INTEG   = 3'd2;
    localparam logic [2:0] RULE_SAT     = 3'd3;
    localparam logic [2:0] RULE_POWER   = 3'd4;

    // action codes
    localparam logic [2:0] ACT_RECLAIM   = 3'd0;
    localparam logic [2:0] ACT_TRIM      = 3'd1;
    localparam logic [2:0] ACT_ESCALATE  = 3'd2;
    localparam logic [2:0] ACT_SCAN      = 3'd3;
    localparam logic [2:0] ACT_PERF      = 3'd4;
    localparam logic [2:0] ACT_BALANCED  = 3'd5;
    localparam logic [2:0] ACT_POWERSAVE = 3'd6;
    localparam logic [2:0] ACT_REBALANCE = 3'd7;

    // power policy codes
    localparam logic [1:0] POL_PERF = 2'd0;
    localparam logic [1:0] POL_SAVE = 2'd2;

    // config register
    localparam logic       REG_MEM_FLOOR   = 1'b0;
    localparam logic [6:0] MEM_FLOOR_RESET = 7'd10;

    localparam logic [6:0] PCT_SCALE     = 7'd100;
    localparam int         LOAD_ONE_SHIFT = 11;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [2:0]           bias;
    } pair_set_t;

    function automatic logic [2:0] bias_for(input logic [1:0] policy);
        logic [2:0] act;
        priority if (policy == POL_PERF) act = ACT_PERF;
        else if (policy == POL_SAVE)     act = ACT_POWERSAVE;
        else                             act = ACT_BALANCED;
        return act;
    endfunction

    function automatic logic [2:0] slot_rule(input logic [SLOT_IDX_W-1:0] idx);
        logic [2:0] r;
        unique case (idx)
            SLOT_RECLAIM:                 r = RULE_MEM;
            SLOT_TRIM, SLOT_THERM_SCN:    r = RULE_THERMAL;
            SLOT_ESCALATE:                r = RULE_INTEG;
            SLOT_SAT_SCN, SLOT_REBALANCE: r = RULE_SAT;
            default:                      r = RULE_POWER;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] slot_action(input logic [SLOT_IDX_W-1:0] idx,
                                               input logic [2:0]            bias);
        logic [2:0] a;
        unique case (idx)
            SLOT_RECLAIM:                 a = ACT_RECLAIM;
            SLOT_TRIM:                    a = ACT_TRIM;
            SLOT_THERM_SCN, SLOT_SAT_SCN: a = ACT_SCAN;
            SLOT_ESCALATE:                a = ACT_ESCALATE;
            SLOT_REBALANCE:               a = ACT_REBALANCE;
            default:                      a = bias;
        endcase
        return a;
    endfunction

endpackage

[src/her_rule_eval.sv]
// rule evaluation with edge-detect state for the health edge rule engine
// depends on her_pkg
module her_rule_eval
    import her_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [6:0]  mem_floor,
    input  logic [31:0] free_pages,
    input  logic [31:0] total_pages,
    input  logic        thermal_flag,
    input  logic [31:0] issue_total,
    input  logic [31:0] load_q11,
    input  logic [12:0] cpus_online,
    input  logic [1:0]  policy_code,
    output pair_set_t   pairs
);

    logic        pressure_seen_reg;
    logic        thermal_seen_reg;
    logic        saturation_seen_reg;
    logic [31:0] prior_issue_reg;
    logic [1:0]  prior_policy_reg;
    logic        primed_reg;

    logic [38:0]          free_scaled;
    logic [38:0]          floor_scaled;
    logic [31:0]          sat_limit;
    logic                 pressure;
    logic                 saturation;
    logic [NUM_SLOTS-1:0] raw_mask;
    logic [NUM_SLOTS-1:0] kept_mask;

    always_comb
    begin
        logic [CNT_W-1:0] kept_cnt;
        free_scaled  = 39'(free_pages) * 39'(PCT_SCALE);
        floor_scaled = 39'(mem_floor) * 39'(total_pages);
        pressure     = (total_pages != 32'd0) && (free_scaled < floor_scaled);
        sat_limit    = 32'(cpus_online) << LOAD_ONE_SHIFT;
        saturation   = (cpus_online != 13'd0) && (load_q11 > sat_limit);

        raw_mask                 = '0;
        raw_mask[SLOT_RECLAIM]   = pressure && !pressure_seen_reg;
        raw_mask[SLOT_TRIM]      = thermal_flag && !thermal_seen_reg;
        raw_mask[SLOT_THERM_SCN] = thermal_flag && !thermal_seen_reg;
        raw_mask[SLOT_ESCALATE]  = primed_reg && (issue_total > prior_issue_reg);
        raw_mask[SLOT_SAT_SCN]   = saturation && !saturation_seen_reg;
        raw_mask[SLOT_REBALANCE] = saturation && !saturation_seen_reg;
        raw_mask[SLOT_BIAS]      = !primed_reg || (policy_code != prior_policy_reg);

        // keep only the first pairs up to capacity
        kept_cnt  = '0;
        kept_mask = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (raw_mask[i] && (kept_cnt < CNT_W'(ACTION_CAP)))
            begin
                kept_mask[i] = 1'b1;
                kept_cnt     = kept_cnt + 1'b1;
            end
        end

        pairs.mask = kept_mask;
        pairs.bias = bias_for(policy_code);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_seen_reg   <= 1'b0;
            thermal_seen_reg    <= 1'b0;
            saturation_seen_reg <= 1'b0;
            prior_issue_reg     <= '0;
            prior_policy_reg    <= '0;
            primed_reg          <= 1'b0;
        end
        else if (fire)
        begin
            pressure_seen_reg   <= pressure;
            thermal_seen_reg    <= thermal_flag;
            saturation_seen_reg <= saturation;
            prior_issue_reg     <= issue_total;
            prior_policy_reg    <= policy_code;
            primed_reg          <= 1'b1;
        end
    end

endmodule

[src/her_pair_queue.sv]
// result register holding the pending pairs of one sample, shifted out lowest slot first
// depends on her_pkg and assert_macros.svh
`include "assert_macros.svh"

module her_pair_queue
    import her_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  pair_set_t  pairs,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] rule_code,
    output logic [2:0] action_code,
    output logic       last_of_run
);

    logic [NUM_SLOTS-1:0] mask_reg;
    logic [2:0]           bias_reg;
    logic [NUM_SLOTS-1:0] pick;
    logic [NUM_SLOTS-1:0] rest;
    logic [SLOT_IDX_W-1:0] pick_idx;
    logic                 pop;

    always_comb
    begin
        pick     = mask_reg & (~mask_reg + 1'b1);
        rest     = mask_reg & ~pick;
        pick_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick[i])
            begin
                pick_idx = SLOT_IDX_W'(i);
            end
        end
    end

    assign out_valid   = (mask_reg != '0);
    assign pop         = out_valid && !out_stall;
    assign can_load    = !out_valid || (pop && (rest == '0));
    assign rule_code   = slot_rule(pick_idx);
    assign action_code = slot_action(pick_idx, bias_reg);
    assign last_of_run = (rest == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (load)
        begin
            mask_reg <= pairs.mask;
        end
        else if (pop)
        begin
            mask_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bias_reg <= pairs.bias;
        end
    end

    `HER_ASSERT(a_cap_respected, $countones(mask_reg) <= ACTION_CAP, "pending pairs exceed capacity")
    `HER_ASSERT(a_no_overwrite, !load || can_load, "pairs loaded over a pending run")
    `HER_ASSERT_NEXT(a_pop_shrinks, pop && !load, $countones(mask_reg) == $countones($past(mask_reg)) - 1, "pop did not retire exactly one pair")

endmodule

[src/health_edge_rule_engine.sv]
// an item is registered in the input register on accept, evaluated there once the result register
// can take its pairs, and its first pair then shows on the output from the result register
// throughput: one item per cycle while each item yields at most one pair and out_stall is low;
// multi-pair items hold the result register until drained, so the pair drain port sets the sustained rate
// reset (rst_n, async, active low): edge state cleared, not primed, floor register 10, no item held
module health_edge_rule_engine
    import her_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] free_pages,
    input  logic [31:0] total_pages,
    input  logic        thermal_flag,
    input  logic [31:0] issue_total,
    input  logic [31:0] load_q11,
    input  logic [12:0] cpus_online,
    input  logic [1:0]  policy_code,
    // pair channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  rule_code,
    output logic [2:0]  action_code,
    output logic        last_of_run
);

    // config register, one word per register at byte stride 4
    logic [6:0] mem_floor_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MEM_FLOOR) ? {25'd0, mem_floor_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_floor_reg <= MEM_FLOOR_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_MEM_FLOOR))
        begin
            mem_floor_reg <= pwdata[6:0];
        end
    end

    // input register: holds one sample until the result register can take its pairs
    logic        s1_valid_reg;
    logic [31:0] free_reg;
    logic [31:0] total_reg;
    logic        thermal_reg;
    logic [31:0] issue_reg;
    logic [31:0] load_reg;
    logic [12:0] cpus_reg;
    logic [1:0]  policy_reg;

    logic      in_accept;
    logic      advance;
    logic      q_can_load;
    pair_set_t pairs;

    // the sample moves on (and the edge state updates) when the result register frees up
    assign advance   = s1_valid_reg && q_can_load;
    // the input register empties in the same cycle it advances, so a new item may follow
    assign in_stall  = s1_valid_reg && !q_can_load;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            free_reg    <= free_pages;
            total_reg   <= total_pages;
            thermal_reg <= thermal_flag;
            issue_reg   <= issue_total;
            load_reg    <= load_q11;
            cpus_reg    <= cpus_online;
            policy_reg  <= policy_code;
        end
    end

    // rule checks against the edge state; yields the mask of pairs to emit
    her_rule_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .mem_floor    (mem_floor_reg),
        .free_pages   (free_reg),
        .total_pages  (total_reg),
        .thermal_flag (thermal_reg),
        .issue_total  (issue_reg),
        .load_q11     (load_reg),
        .cpus_online  (cpus_reg),
        .policy_code  (policy_reg),
        .pairs        (pairs)
    );

    // result register; a sample with no pairs loads an empty mask and produces nothing
    her_pair_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .pairs       (pairs),
        .can_load    (q_can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rule_code   (rule_code),
        .action_code (action_code),
        .last_of_run (last_of_run)
    );

endmodule
